// ----- rtl/ucws_pkg.sv -----
// Package for the UTF-8 character window stream core.
// Holds field widths, register indexes, mode and status codes, and lead byte decoding.
// No dependencies.
package ucws_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int BYTE_W         = 8;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int TOTAL_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int SKIP_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_LIMIT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUBSTR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_LEAD = 2'd1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic                is_status;
        logic [BYTE_W-1:0]   out_byte;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  char_total;
    } t_out_item;

    // Number of bytes announced by a lead byte, zero if the byte is no valid lead.
    function automatic logic [2:0] lead_width(input logic [BYTE_W-1:0] b);
        logic [2:0] w;
        begin
            if (b[7] == 1'b0) begin
                w = 3'd1;
            end else if ((b & 8'hE0) == 8'hC0) begin
                w = 3'd2;
            end else if ((b & 8'hF0) == 8'hE0) begin
                w = 3'd3;
            end else if ((b & 8'hF8) == 8'hF0) begin
                w = 3'd4;
            end else begin
                w = 3'd0;
            end
            return w;
        end
    endfunction

endpackage

// ----- rtl/ucws_if.sv -----
// Handshake interfaces for the byte input, result output and register write channels.
// Depends on ucws_pkg for field widths.
interface ucws_in_if;
    import ucws_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;
    modport source (output valid, in_byte, last_byte, input ready);
    modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface ucws_out_if;
    import ucws_pkg::*;
    logic                valid;
    logic                ready;
    logic                is_status;
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  char_total;
    modport source (output valid, is_status, out_byte, status, char_total, input ready);
    modport sink (input valid, is_status, out_byte, status, char_total, output ready);
endinterface

interface ucws_cfg_if;
    import ucws_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/utf8_char_window_stream_core.sv -----
// Top level of the UTF-8 character window stream core.
// Depends on ucws_pkg and the interfaces in ucws_if.sv.
// A byte is captured in the input register, then written into the result queue once the queue
// has room; the queue head drives the output.
// Throughput: one byte per cycle while the result queue (depth four) has two free entries; a
// last byte that also yields a data byte writes both a data and a status result to the queue.
// Reset clears registers, stream state and the queue; no clearing pass is needed.
module utf8_char_window_stream_core #(
    parameter int COUNT_BITS = ucws_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ucws_in_if.sink          i_in,
    ucws_cfg_if.sink         i_cfg,
    ucws_out_if.source       o_out
);
    import ucws_pkg::*;

    localparam int CMP_W   = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    logic [MODE_W-1:0]     r_mode;
    logic [TOTAL_W-1:0]    r_start_char;
    logic [TOTAL_W-1:0]    r_char_limit;

    logic                  r_in_vld;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  r_in_last;

    logic [SKIP_W-1:0]     r_skip, n_skip;
    logic [COUNT_BITS-1:0] r_index, n_index;
    logic [COUNT_BITS-1:0] r_copied, n_copied;
    logic                  r_char_sel, n_char_sel;
    logic                  r_stopped, n_stopped;
    logic [1:0]            r_err, n_err;

    t_out_item             r_q [QDEPTH];
    logic [QPTR_W-1:0]     r_wr, r_rd;
    logic [QCNT_W-1:0]     r_cnt;

    logic                  w_adv;
    logic                  w_emit;
    logic [MODE_W-1:0]     w_mode;
    logic [2:0]            w_lead;
    logic                  w_done;
    logic                  w_sel;
    logic [CMP_W-1:0]      w_index_x, w_copied_x, w_start_x, w_limit_x, w_total_x;
    logic [STATUS_W-1:0]   w_status;
    t_out_item             w_data_item, w_stat_item;
    logic                  w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_COUNT;
            r_start_char <= '0;
            r_char_limit <= TOTAL_W'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:       r_mode <= i_cfg.data[MODE_W-1:0];
                REG_START_CHAR: r_start_char <= i_cfg.data[TOTAL_W-1:0];
                REG_CHAR_LIMIT: r_char_limit <= i_cfg.data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = r_in_vld && (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign i_in.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    assign w_mode     = (r_mode == MODE_UNUSED) ? MODE_COUNT : r_mode;
    assign w_lead     = lead_width(r_in_byte);
    assign w_index_x  = CMP_W'(r_index);
    assign w_copied_x = CMP_W'(r_copied);
    assign w_start_x  = CMP_W'(r_start_char);
    assign w_limit_x  = CMP_W'(r_char_limit);
    assign w_done     = ((w_mode == MODE_CHAR) && (r_copied != '0)) ||
                        ((w_mode == MODE_SUBSTR) && (w_copied_x >= w_limit_x));
    assign w_sel      = ((w_mode == MODE_CHAR) && (w_index_x == w_start_x)) ||
                        ((w_mode == MODE_SUBSTR) && (w_index_x >= w_start_x));

    always_comb begin
        n_skip     = r_skip;
        n_index    = r_index;
        n_copied   = r_copied;
        n_char_sel = r_char_sel;
        n_stopped  = r_stopped;
        n_err      = r_err;
        w_emit     = 1'b0;
        if (r_skip != '0) begin
            n_skip = r_skip - SKIP_W'(1);
            w_emit = r_char_sel;
            if (n_skip == '0) begin
                n_char_sel = 1'b0;
            end
        end else if (!r_stopped) begin
            if (w_done) begin
                n_stopped = 1'b1;
            end else if (w_lead == 3'd0) begin
                n_err     = ERR_BAD_LEAD;
                n_stopped = 1'b1;
            end else begin
                if (w_sel && (r_copied != '1)) begin
                    n_copied = r_copied + COUNT_BITS'(1);
                end
                if (r_index != '1) begin
                    n_index = r_index + COUNT_BITS'(1);
                end
                n_skip     = SKIP_W'(w_lead - 3'd1);
                n_char_sel = w_sel && (w_lead != 3'd1);
                w_emit     = w_sel;
            end
        end
    end

    always_comb begin
        w_total_x = (w_mode == MODE_COUNT) ? CMP_W'(n_index) : CMP_W'(n_copied);
        priority if ((w_mode == MODE_SUBSTR) && (r_char_limit == '0)) begin
            w_status = ST_ZERO_LEN;
        end else if (n_err != ERR_NONE) begin
            w_status = ST_BAD_LEAD;
        end else if ((w_mode == MODE_CHAR) && (n_copied == '0)) begin
            w_status = ST_NOT_FOUND;
        end else begin
            w_status = ST_OK;
        end
        w_data_item.is_status  = 1'b0;
        w_data_item.out_byte   = r_in_byte;
        w_data_item.status     = ST_OK;
        w_data_item.char_total = '0;
        w_stat_item.is_status  = 1'b1;
        w_stat_item.out_byte   = '0;
        w_stat_item.status     = w_status;
        w_stat_item.char_total = (w_total_x > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                 : w_total_x[TOTAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip     <= '0;
            r_index    <= '0;
            r_copied   <= '0;
            r_char_sel <= 1'b0;
            r_stopped  <= 1'b0;
            r_err      <= ERR_NONE;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_skip     <= '0;
                r_index    <= '0;
                r_copied   <= '0;
                r_char_sel <= 1'b0;
                r_stopped  <= 1'b0;
                r_err      <= ERR_NONE;
            end else begin
                r_skip     <= n_skip;
                r_index    <= n_index;
                r_copied   <= n_copied;
                r_char_sel <= n_char_sel;
                r_stopped  <= n_stopped;
                r_err      <= n_err;
            end
        end
    end

    assign w_pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_emit) begin
                r_q[r_wr] <= w_data_item;
                if (r_in_last) begin
                    r_q[r_wr + QPTR_W'(1)] <= w_stat_item;
                end
            end else if (r_in_last) begin
                r_q[r_wr] <= w_stat_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_adv) begin
                r_wr <= r_wr + QPTR_W'(w_emit) + QPTR_W'(r_in_last);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (w_adv ? (QCNT_W'(w_emit) + QCNT_W'(r_in_last)) : '0)
                     - QCNT_W'(w_pop);
        end
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.is_status  = r_q[r_rd].is_status;
    assign o_out.out_byte   = r_q[r_rd].out_byte;
    assign o_out.status     = r_q[r_rd].status;
    assign o_out.char_total = r_q[r_rd].char_total;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("result queue count exceeds its depth");

    a_skip_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0) |-> !r_stopped)
        else $error("continuation bytes pending while the scan is stopped");

    a_sel_needs_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_sel |-> (r_skip != '0))
        else $error("character selected with no continuation bytes pending");

    a_copied_le_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_copied <= r_index)
        else $error("copied characters exceed characters scanned");

endmodule

// ----- dv/utf8_char_window_stream_core_tb.sv -----
// Testbench for the UTF-8 character window stream core: directed strings, random strings
// and output back-pressure, all checked against a built-in predictor.
// Depends on ucws_pkg, the interfaces in ucws_if.sv and utf8_char_window_stream_core.
`timescale 1ns / 100ps

module utf8_char_window_stream_core_tb;
    import ucws_pkg::*;

    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 6;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_NS      = 5_000_000;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    ucws_in_if  in_if ();
    ucws_out_if out_if ();
    ucws_cfg_if cfg_if ();

    utf8_char_window_stream_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    logic [MODE_W-1:0]         cfg_mode  = MODE_COUNT;
    logic [CFG_DATA_W-1:0]     cfg_start = '0;
    logic [CFG_DATA_W-1:0]     cfg_limit = 16'd1;
    logic [SKIP_W-1:0]         skip_left = '0;
    logic [COUNT_BITS_DEF-1:0] char_idx  = '0;
    logic [COUNT_BITS_DEF-1:0] copied    = '0;
    logic                      cur_selected = 1'b0;
    logic                      scan_stopped = 1'b0;
    logic                      bad_lead     = 1'b0;

    t_out_item window_results[$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_trig      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic int lead_bytes(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic void predict_window_results(input logic [7:0] b, input logic last);
        logic [MODE_W-1:0]   m;
        logic [STATUS_W-1:0] st;
        t_out_item           item;
        int                  width;
        logic                emit;
        logic                hit;
        m = (cfg_mode == MODE_UNUSED) ? MODE_COUNT : cfg_mode;
        emit = 1'b0;
        if (skip_left != 0) begin
            skip_left = skip_left - SKIP_W'(1);
            emit = cur_selected;
            if (skip_left == 0) cur_selected = 1'b0;
        end else if (!scan_stopped) begin
            width = lead_bytes(b);
            if ((m == MODE_CHAR && copied != 0) || (m == MODE_SUBSTR && copied >= cfg_limit)) begin
                scan_stopped = 1'b1;
            end else if (width == 0) begin
                bad_lead = 1'b1;
                scan_stopped = 1'b1;
            end else begin
                hit = (m == MODE_CHAR && char_idx == cfg_start) ||
                      (m == MODE_SUBSTR && char_idx >= cfg_start);
                if (hit && copied != COUNT_MAX) copied = copied + COUNT_BITS_DEF'(1);
                if (char_idx != COUNT_MAX) char_idx = char_idx + COUNT_BITS_DEF'(1);
                skip_left = SKIP_W'(width - 1);
                cur_selected = hit && (width > 1);
                emit = hit;
            end
        end
        if (emit) begin
            item = '0;
            item.out_byte = b;
            window_results.push_back(item);
        end
        if (last) begin
            if (m == MODE_SUBSTR && cfg_limit == 0) begin
                st = ST_ZERO_LEN;
            end else if (bad_lead) begin
                st = ST_BAD_LEAD;
            end else if (m == MODE_CHAR && copied == 0) begin
                st = ST_NOT_FOUND;
            end else begin
                st = ST_OK;
            end
            item = '0;
            item.is_status = 1'b1;
            item.status = st;
            item.char_total = (m == MODE_COUNT) ? char_idx : copied;
            window_results.push_back(item);
            skip_left = '0;
            char_idx = '0;
            copied = '0;
            cur_selected = 1'b0;
            scan_stopped = 1'b0;
            bad_lead = 1'b0;
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (window_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("unexpected result: is_status=%0b byte=%h status=%0d total=%0d",
                         got.is_status, got.out_byte, got.status, got.char_total);
            end
        end else begin
            want = window_results.pop_front();
            if (got.is_status !== want.is_status || got.out_byte !== want.out_byte ||
                got.status !== want.status || got.char_total !== want.char_total) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("mismatch: expected is_status=%0b byte=%h status=%0d total=%0d",
                             want.is_status, want.out_byte, want.status, want.char_total);
                    $display("          actual   is_status=%0b byte=%h status=%0d total=%0d",
                             got.is_status, got.out_byte, got.status, got.char_total);
                end
            end
        end
    endfunction

    // Result sink: random stalls, plus a long hold-off when a test requests one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_result({out_if.is_status, out_if.out_byte, out_if.status,
                              out_if.char_total});
            end
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.in_byte <= b;
        in_if.last_byte <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_window_results(b, last);
    endtask

    // Bytes without a result may still be in flight once the queue is empty.
    task automatic wait_stream_idle();
        in_if.valid <= 1'b0;
        while (window_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_stream_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mode = value[MODE_W-1:0];
            REG_START_CHAR: cfg_start = value;
            REG_CHAR_LIMIT: cfg_limit = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [MODE_W-1:0] m, input logic [CFG_DATA_W-1:0] start,
                             input logic [CFG_DATA_W-1:0] limit);
        write_reg(REG_MODE, CFG_DATA_W'(m));
        write_reg(REG_START_CHAR, start);
        write_reg(REG_CHAR_LIMIT, limit);
    endtask

    task automatic test_count_all_widths();
        send_byte(8'h00, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_char_at_index();
        configure(MODE_CHAR, 16'd1, 16'd1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    task automatic test_bad_lead_and_zero_length();
        configure(MODE_SUBSTR, 16'd0, 16'd1);
        send_byte(8'hFF, 1'b1);
        write_reg(REG_CHAR_LIMIT, 16'd0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_window_past_end();
        configure(MODE_CHAR, 16'd0, 16'd1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b1);
        write_reg(REG_START_CHAR, 16'hFFFF);
        send_byte(8'h41, 1'b1);
        configure(MODE_SUBSTR, 16'hFFFF, 16'hFFFF);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_mode_change_mid_string();
        configure(MODE_UNUSED, 16'd0, 16'd1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        configure(MODE_SUBSTR, 16'd0, 16'hFFFF);
        send_byte(8'h43, 1'b1);
    endtask

    task automatic test_random_strings(input int n_items);
        logic [7:0]      text[$];
        logic [7:0]      lead;
        logic [7:0]      rnd;
        logic [CFG_DATA_W-1:0] start;
        logic [CFG_DATA_W-1:0] limit;
        int              sent;
        int              width;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(9))
                    0:       start = 16'hFFFF;
                    1:       start = CFG_DATA_W'($urandom);
                    default: start = CFG_DATA_W'($urandom_range(6));
                endcase
                case ($urandom_range(9))
                    0:       limit = 16'd0;
                    1:       limit = 16'hFFFF;
                    default: limit = CFG_DATA_W'($urandom_range(1, 5));
                endcase
                configure(MODE_W'($urandom_range(3)), start, limit);
            end
            text.delete();
            width = 1;
            if ($urandom_range(6) == 0) begin
                repeat ($urandom_range(1, 12)) text.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    width = $urandom_range(1, 4);
                    lead = 8'($urandom);
                    case (width)
                        1: lead[7] = 1'b0;
                        2: lead[7:5] = 3'b110;
                        3: lead[7:4] = 4'b1110;
                        default: lead[7:3] = 5'b11110;
                    endcase
                    if ($urandom_range(24) == 0) begin
                        rnd = 8'($urandom);
                        lead = $urandom_range(1) ? {2'b10, rnd[5:0]} : {5'b11111, rnd[2:0]};
                    end
                    text.push_back(lead);
                    repeat (width - 1) begin
                        rnd = 8'($urandom);
                        text.push_back(($urandom_range(7) == 0) ? rnd : {2'b10, rnd[5:0]});
                    end
                end
                if (width > 1 && $urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, width - 1)) void'(text.pop_back());
                end
            end
            foreach (text[i]) send_byte(text[i], i == text.size() - 1);
            sent += text.size();
        end
    endtask

    task automatic test_output_backpressure();
        logic [7:0] rnd;
        configure(MODE_CHAR, 16'd0, 16'd1);
        hold_trig++;
        repeat (40) begin
            rnd = 8'($urandom);
            send_byte({1'b0, rnd[6:0]}, 1'b1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        in_if.last_byte = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_stall_pct = 56;
        test_count_all_widths();
        test_char_at_index();
        test_bad_lead_and_zero_length();
        test_window_past_end();
        test_mode_change_mid_string();
        test_random_strings(RANDOM_ITEMS / 3);

        send_idle_pct = 56;
        recv_stall_pct = 24;
        test_random_strings(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_output_backpressure();
        test_random_strings(RANDOM_ITEMS / 3);

        wait_stream_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && window_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
